// ===== hw/rtl/sup_pkg.sv =====
`timescale 1ns / 1ps
// sup_pkg: shared types, character codes and the expansion text table
// for the septet unpacker; no dependencies

package sup_pkg;

    localparam int CH_W            = 7;
    localparam int TAIL_LEN        = 11;
    localparam int TEXT_LEN        = 110;
    localparam int TEXT_IDX_W      = 7;
    localparam int TEXT_CNT_W      = 5;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CH_W-1:0] CH_BANG = 7'h21;
    localparam logic [CH_W-1:0] CH_GT   = 7'h3E;
    localparam logic [CH_W-1:0] CH_BAR  = 7'h7C;
    localparam logic [CH_W-1:0] CH_DOL  = 7'h24;
    localparam logic [CH_W-1:0] CH_AT   = 7'h40;
    localparam logic [CH_W-1:0] CH_UA   = 7'h41;
    localparam logic [CH_W-1:0] CH_LA   = 7'h61;
    localparam logic [CH_W-1:0] CH_UB   = 7'h42;
    localparam logic [CH_W-1:0] CH_UC   = 7'h43;
    localparam logic [CH_W-1:0] CH_UF   = 7'h46;
    localparam logic [CH_W-1:0] CH_UI   = 7'h49;
    localparam logic [CH_W-1:0] CH_UP   = 7'h50;
    localparam logic [CH_W-1:0] CH_US   = 7'h53;
    localparam logic [CH_W-1:0] CH_UU   = 7'h55;

    // trigger phrase, oldest character first
    localparam logic [CH_W-1:0] TRIGGER [TAIL_LEN] = '{
        7'h6C, 7'h6F, 7'h61, 7'h64, 7'h65, 7'h64, 7'h20, 7'h6B, 7'h65, 7'h78, 7'h74
    };

    // packed expansion strings; short prefixes reuse the head of longer ones
    localparam logic [CH_W-1:0] TEXT_ROM [TEXT_LEN] = '{
        // driver prefix, offset 0
        7'h63, 7'h6F, 7'h6D, 7'h2E, 7'h61, 7'h70, 7'h70, 7'h6C, 7'h65, 7'h2E,
        7'h64, 7'h72, 7'h69, 7'h76, 7'h65, 7'h72, 7'h2E,
        // iokit prefix, offset 17
        7'h63, 7'h6F, 7'h6D, 7'h2E, 7'h61, 7'h70, 7'h70, 7'h6C, 7'h65, 7'h2E,
        7'h69, 7'h6F, 7'h6B, 7'h69, 7'h74, 7'h2E,
        // security prefix, offset 33
        7'h63, 7'h6F, 7'h6D, 7'h2E, 7'h61, 7'h70, 7'h70, 7'h6C, 7'h65, 7'h2E,
        7'h73, 7'h65, 7'h63, 7'h75, 7'h72, 7'h69, 7'h74, 7'h79, 7'h2E,
        // words from offset 52
        7'h41, 7'h63, 7'h74, 7'h69, 7'h6F, 7'h6E,
        7'h42, 7'h6C, 7'h75, 7'h65, 7'h74, 7'h6F, 7'h6F, 7'h74, 7'h68,
        7'h43, 7'h6F, 7'h6E, 7'h74, 7'h72, 7'h6F, 7'h6C, 7'h6C, 7'h65, 7'h72,
        7'h46, 7'h61, 7'h6D, 7'h69, 7'h6C, 7'h79,
        7'h49, 7'h6E, 7'h74, 7'h65, 7'h6C,
        7'h50, 7'h72, 7'h6F, 7'h66, 7'h69, 7'h6C, 7'h65,
        7'h53, 7'h74, 7'h6F, 7'h72, 7'h61, 7'h67, 7'h65,
        7'h41, 7'h70, 7'h70, 7'h6C, 7'h65, 7'h55, 7'h53, 7'h42
    };

    typedef struct packed {
        logic [CH_W-1:0] c0;
        logic [CH_W-1:0] c1;
        logic            two;
        logic            eod;
    } t_ent;

    typedef struct packed {
        logic vld;
        t_ent ent;
    } t_slot;

    typedef struct packed {
        logic                  hit;
        logic [TEXT_IDX_W-1:0] start;
        logic [TEXT_CNT_W-1:0] len;
    } t_text;

    function automatic t_text text_lookup(input logic [CH_W-1:0] c, input logic bang);
        t_text t;
        t = '{hit: 1'b0, start: '0, len: '0};
        unique case (c)
            CH_GT:   t = '{hit: 1'b1, start: 7'd0,  len: 5'd17};
            CH_BAR:  t = '{hit: 1'b1, start: 7'd17, len: 5'd16};
            CH_DOL:  t = '{hit: 1'b1, start: 7'd33, len: 5'd19};
            CH_AT:   t = '{hit: 1'b1, start: 7'd0,  len: 5'd10};
            default: begin
                if (bang) begin
                    unique case (c)
                        CH_UA:   t = '{hit: 1'b1, start: 7'd102, len: 5'd5};
                        CH_LA:   t = '{hit: 1'b1, start: 7'd52,  len: 5'd6};
                        CH_UB:   t = '{hit: 1'b1, start: 7'd58,  len: 5'd9};
                        CH_UC:   t = '{hit: 1'b1, start: 7'd67,  len: 5'd10};
                        CH_UF:   t = '{hit: 1'b1, start: 7'd77,  len: 5'd6};
                        CH_UI:   t = '{hit: 1'b1, start: 7'd83,  len: 5'd5};
                        CH_UP:   t = '{hit: 1'b1, start: 7'd88,  len: 5'd7};
                        CH_US:   t = '{hit: 1'b1, start: 7'd95,  len: 5'd7};
                        CH_UU:   t = '{hit: 1'b1, start: 7'd102, len: 5'd8};
                        default: t = '{hit: 1'b0, start: '0, len: '0};
                    endcase
                end
            end
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/sup_if.sv =====
`timescale 1ns / 1ps
// sup_in_if / sup_out_if: valid-ready channels of the septet unpacker
// no dependencies

interface sup_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       end_of_data;

    modport source (output valid, output packed_byte, output end_of_data, input ready);
    modport sink   (input valid, input packed_byte, input end_of_data, output ready);
endinterface

interface sup_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       run_last;

    modport source (output valid, output out_char, output run_last, input ready);
    modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

// ===== hw/rtl/sup_front.sv =====
`timescale 1ns / 1ps
// sup_front: accepts packed bytes and splits them into one or two characters
// depends on sup_pkg and sup_in_if

module sup_front
    import sup_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    sup_in_if.sink       i_in,
    input  logic         i_full,
    output t_slot        o_push
);

    logic [2:0]      r_bit;
    logic [CH_W-1:0] r_carry;
    logic [2:0]      bit_e;
    logic [14:0]     lo_sh;
    logic [7:0]      hi_sh;
    logic            acc;
    logic            two;

    assign bit_e = (r_bit > 3'd6) ? 3'd0 : r_bit;
    assign lo_sh = {7'd0, i_in.packed_byte} << bit_e;
    assign hi_sh = i_in.packed_byte >> (3'd7 - bit_e);
    assign two   = (bit_e == 3'd6);
    assign acc   = i_in.valid && !i_full;

    assign i_in.ready     = !i_full;
    assign o_push.vld     = acc;
    assign o_push.ent.c0  = lo_sh[6:0] | r_carry;
    assign o_push.ent.c1  = hi_sh[6:0];
    assign o_push.ent.two = two;
    assign o_push.ent.eod = i_in.end_of_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit   <= '0;
            r_carry <= '0;
        end else if (acc) begin
            if (i_in.end_of_data || two) begin
                r_bit   <= '0;
                r_carry <= '0;
            end else begin
                r_bit   <= bit_e + 3'd1;
                r_carry <= hi_sh[6:0];
            end
        end
    end

endmodule

// ===== hw/rtl/sup_queue.sv =====
`timescale 1ns / 1ps
// sup_queue: short fifo of unpacked beats between front and back
// depends on sup_pkg

module sup_queue
    import sup_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_slot i_push,
    input  logic  i_pop,
    output t_slot o_head,
    output logic  o_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_ent          r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full     = (r_cnt == CW'(DEPTH));
    assign o_head.vld = (r_cnt != '0);
    assign o_head.ent = r_mem[r_rp];
    assign do_push    = i_push.vld && !o_full;
    assign do_pop     = i_pop && o_head.vld;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/sup_back.sv =====
`timescale 1ns / 1ps
// sup_back: trigger watch, mark holding and text expansion, at most one character a cycle while o_out is not stalled
// depends on sup_pkg and sup_out_if

module sup_back
    import sup_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_slot    i_head,
    output logic     o_pop,
    sup_out_if.source o_out
);

    localparam logic [1:0] ST_CHAR = 2'd0;
    localparam logic [1:0] ST_TEXT = 2'd1;
    localparam logic [1:0] ST_LIT  = 2'd2;
    localparam logic [1:0] ST_END  = 2'd3;

    logic [1:0]            r_st,   n_st;
    logic                  r_ph,   n_ph;
    logic                  r_bang, n_bang;
    logic                  r_exp,  n_exp;
    logic [TEXT_IDX_W-1:0] r_idx,  n_idx;
    logic [TEXT_CNT_W-1:0] r_left, n_left;
    logic [CH_W-1:0]       r_tail [TAIL_LEN];
    logic                  r_stg_vld;
    logic [CH_W-1:0]       r_stg_chr;
    logic                  r_out_vld;
    logic [CH_W-1:0]       r_out_chr;
    logic                  r_out_last;

    logic [CH_W-1:0] cur;
    logic            tail_hit;
    t_text           lk;
    logic            go;
    logic            emit;
    logic [CH_W-1:0] emit_chr;
    logic            fin;
    logic            adv;
    logic            tail_shift;
    logic            out_load;

    assign cur = r_ph ? i_head.ent.c1 : i_head.ent.c0;
    assign lk  = text_lookup(cur, r_bang);
    assign go  = i_head.vld && (!r_stg_vld || !r_out_vld || o_out.ready);

    always_comb begin
        tail_hit = 1'b1;
        for (int k = 0; k < TAIL_LEN; k++) begin
            if (r_tail[k] != TRIGGER[k]) begin
                tail_hit = 1'b0;
            end
        end
    end

    always_comb begin
        n_st       = r_st;
        n_ph       = r_ph;
        n_bang     = r_bang;
        n_exp      = r_exp;
        n_idx      = r_idx;
        n_left     = r_left;
        emit       = 1'b0;
        emit_chr   = cur;
        fin        = 1'b0;
        adv        = 1'b0;
        tail_shift = 1'b0;
        if (go) begin
            unique case (r_st)
                ST_CHAR: begin
                    if (!r_exp && !tail_hit) begin
                        emit       = 1'b1;
                        tail_shift = 1'b1;
                        adv        = 1'b1;
                    end else begin
                        n_exp = 1'b1;
                        if (lk.hit) begin
                            n_bang = 1'b0;
                            n_idx  = lk.start;
                            n_left = lk.len;
                            n_st   = ST_TEXT;
                        end else if (r_bang) begin
                            emit     = 1'b1;
                            emit_chr = CH_BANG;
                            if (cur == CH_BANG) begin
                                adv = 1'b1;
                            end else begin
                                n_bang = 1'b0;
                                n_st   = ST_LIT;
                            end
                        end else if (cur == CH_BANG) begin
                            n_bang = 1'b1;
                            adv    = 1'b1;
                        end else begin
                            emit = 1'b1;
                            adv  = 1'b1;
                        end
                    end
                end
                ST_TEXT: begin
                    emit     = 1'b1;
                    emit_chr = TEXT_ROM[r_idx];
                    n_idx    = r_idx + 1'b1;
                    n_left   = r_left - 1'b1;
                    adv      = (r_left == TEXT_CNT_W'(1));
                end
                ST_LIT: begin
                    emit = 1'b1;
                    adv  = 1'b1;
                end
                ST_END: begin
                    if (i_head.ent.eod && r_bang) begin
                        emit     = 1'b1;
                        emit_chr = CH_BANG;
                        n_bang   = 1'b0;
                    end else begin
                        fin = 1'b1;
                    end
                end
                default: n_st = ST_CHAR;
            endcase
            if (adv) begin
                if (!r_ph && i_head.ent.two) begin
                    n_ph = 1'b1;
                    n_st = ST_CHAR;
                end else begin
                    n_st = ST_END;
                end
            end
            if (fin) begin
                n_st = ST_CHAR;
                n_ph = 1'b0;
                if (i_head.ent.eod) begin
                    n_exp  = 1'b0;
                    n_bang = 1'b0;
                end
            end
        end
    end

    assign out_load = (emit || fin) && r_stg_vld;
    assign o_pop    = fin;

    assign o_out.valid    = r_out_vld;
    assign o_out.out_char = r_out_chr;
    assign o_out.run_last = r_out_last;

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_left <= n_left;
        if (emit) begin
            r_stg_chr <= emit_chr;
        end
        if (out_load) begin
            r_out_chr  <= r_stg_chr;
            r_out_last <= fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_CHAR;
            r_ph      <= 1'b0;
            r_bang    <= 1'b0;
            r_exp     <= 1'b0;
            r_stg_vld <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < TAIL_LEN; k++) begin
                r_tail[k] <= '0;
            end
        end else begin
            r_st   <= n_st;
            r_ph   <= n_ph;
            r_bang <= n_bang;
            r_exp  <= n_exp;
            if (emit) begin
                r_stg_vld <= 1'b1;
            end else if (fin) begin
                r_stg_vld <= 1'b0;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (fin && i_head.ent.eod) begin
                for (int k = 0; k < TAIL_LEN; k++) begin
                    r_tail[k] <= '0;
                end
            end else if (tail_shift) begin
                for (int k = 0; k < TAIL_LEN - 1; k++) begin
                    r_tail[k] <= r_tail[k+1];
                end
                r_tail[TAIL_LEN-1] <= cur;
            end
        end
    end

endmodule

// ===== hw/rtl/septet_unpack_with_name_expansion.sv =====
`timescale 1ns / 1ps
// septet_unpack_with_name_expansion: septet unpacker with name expansion, top level
// depends on sup_pkg, sup_if, sup_front, sup_queue and sup_back
//
// i_in carries packed bytes, seven-bit characters least significant bit first;
// end_of_data marks the last byte of a stream and flushes a held '!'.
// o_out carries one character a beat; run_last flags the last character
// caused by one input byte. A byte that only leaves a '!' held gives no beat.
// The front unpacks one byte a cycle into a queue of QUEUE_DEPTH entries while the queue is not full.
// For each character of a byte the back emits the character, holds a '!',
// emits a released '!' and then the character, or in turn each character of an
// expansion string (up to 19); it then emits any '!' still held at end of data
// and closes the byte. Every seventh byte of a stream carries two characters.
// The last character of a byte is held in a staging register until the byte
// closes, then goes to the output register.
// If o_out stalls, the output register holds its beat, the back stops and the
// queue fills; i_in.ready drops once the queue is full.
// Synchronous reset empties the queue, drops any held character and clears
// the trigger history and expansion mode.

module septet_unpack_with_name_expansion
    import sup_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sup_in_if.sink    i_in,
    sup_out_if.source o_out
);

    t_slot w_push;
    t_slot w_head;
    logic  w_full;
    logic  w_pop;

    sup_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    sup_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full)
    );

    sup_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ===== hw/rtl/sup_checker.sv =====
`timescale 1ns / 1ps
// sup_checker: port-level checks on the septet unpacker, bound to the top level
// no dependencies

module sup_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_char,
    input logic       i_out_last
);

    // output beat holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_char) && $stable(i_out_last)))
        else $error("output payload changed while stalled");

    // reset empties the output register and the queue
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready right after reset");

endmodule

bind septet_unpack_with_name_expansion sup_checker u_sup_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.run_last)
);

// ===== dv/septet_unpack_with_name_expansion_tb.sv =====
`timescale 1ns / 1ps
// septet_unpack_with_name_expansion_tb: self-checking bench for the septet unpacker
// depends on sup_pkg, sup_if and the septet_unpack_with_name_expansion top level
// a class predicts the character beats of each accepted byte and checks them in order

module septet_unpack_with_name_expansion_tb;
    import sup_pkg::*;

    localparam int RANDOM_BYTES = 400;
    localparam int LONG_HOLD    = 300;

    localparam logic [CH_W-1:0] PREFIX_KEYS [4] = '{CH_GT, CH_BAR, CH_DOL, CH_AT};
    localparam logic [CH_W-1:0] WORD_KEYS [9] = '{
        CH_UA, CH_LA, CH_UB, CH_UC, CH_UF, CH_UI, CH_UP, CH_US, CH_UU
    };

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } t_beat;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } t_byte_item;

    typedef enum int {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_EVERY_THIRD} t_rx_mode;

    class septet_checker;
        t_beat           expected_q[$];
        t_beat           step_q[$];
        logic [2:0]      bit_pos;
        logic [CH_W-1:0] carry;
        logic [CH_W-1:0] recent [TAIL_LEN];
        bit              exp_on;
        bit              bang_held;
        int              n_fail;
        int              n_beats;
        int              n_bytes;
        int              n_streams;
        int              n_expansions;

        function new();
            clear_stream();
        endfunction

        function void clear_stream();
            bit_pos   = '0;
            carry     = '0;
            exp_on    = 1'b0;
            bang_held = 1'b0;
            foreach (recent[i]) recent[i] = '0;
        endfunction

        function void push_char(logic [CH_W-1:0] c);
            t_beat bt;
            bt.ch   = c;
            bt.last = 1'b0;
            step_q.insert(step_q.size(), bt);
            for (int i = 0; i < TAIL_LEN - 1; i++) recent[i] = recent[i+1];
            recent[TAIL_LEN-1] = c;
        endfunction

        function void push_text(string s);
            byte b8;
            for (int i = 0; i < s.len(); i++) begin
                b8 = s[i];
                push_char(b8[CH_W-1:0]);
            end
        endfunction

        function bit tail_hit();
            for (int i = 0; i < TAIL_LEN; i++) begin
                if (recent[i] != TRIGGER[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function string expansion_for(logic [CH_W-1:0] c, bit bang);
            string dom;
            dom = $sformatf("com.%cpple.", 8'h61);
            case (c)
                CH_GT:   return {dom, "driver."};
                CH_BAR:  return {dom, "iokit."};
                CH_DOL:  return {dom, "security."};
                CH_AT:   return dom;
                default: ;
            endcase
            if (!bang) return "";
            case (c)
                CH_UA:   return $sformatf("%cpple", 8'h41);
                CH_LA:   return "Action";
                CH_UB:   return "Bluetooth";
                CH_UC:   return "Controller";
                CH_UF:   return "Family";
                CH_UI:   return $sformatf("%cntel", 8'h49);
                CH_UP:   return "Profile";
                CH_US:   return "Storage";
                CH_UU:   return $sformatf("%cppleUSB", 8'h41);
                default: return "";
            endcase
        endfunction

        function void decode_char(logic [CH_W-1:0] c);
            string txt;
            if (!exp_on) begin
                if (tail_hit()) begin
                    exp_on = 1'b1;
                end else begin
                    push_char(c);
                    return;
                end
            end
            txt = expansion_for(c, bang_held);
            if (txt.len() > 0) begin
                bang_held = 1'b0;
                n_expansions++;
                push_text(txt);
                return;
            end
            if (bang_held) push_char(CH_BANG);
            if (c == CH_BANG) begin
                bang_held = 1'b1;
            end else begin
                bang_held = 1'b0;
                push_char(c);
            end
        endfunction

        function void note_byte(logic [7:0] b, logic eod);
            logic [2:0] pos;
            logic [7:0] tmp;
            step_q.delete();
            n_bytes++;
            pos = (bit_pos > 3'd6) ? 3'd0 : bit_pos;
            tmp = (b & (8'h7F >> pos)) << pos;
            decode_char(tmp[CH_W-1:0] | carry);
            tmp = b >> (3'd7 - pos);
            carry = tmp[CH_W-1:0];
            if (pos == 3'd6) begin
                decode_char(carry);
                carry   = '0;
                bit_pos = '0;
            end else begin
                bit_pos = pos + 3'd1;
            end
            if (eod) begin
                if (bang_held) push_char(CH_BANG);
                clear_stream();
                n_streams++;
            end
            if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
            foreach (step_q[i]) expected_q.insert(expected_q.size(), step_q[i]);
        endfunction

        function void check_beat(logic [CH_W-1:0] ch, logic last);
            t_beat want;
            n_beats++;
            if (expected_q.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected beat, expected none, actual char %h last %b",
                         $time, ch, last);
                return;
            end
            want = expected_q.pop_front();
            if (ch !== want.ch) begin
                n_fail++;
                $display("%0t: out_char mismatch, expected %h actual %h", $time, want.ch, ch);
            end
            if (last !== want.last) begin
                n_fail++;
                $display("%0t: run_last mismatch, expected %b actual %b",
                         $time, want.last, last);
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sup_in_if  in_if ();
    sup_out_if out_if ();

    septet_unpack_with_name_expansion uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    septet_checker   chk;
    t_byte_item      byte_q[$];
    logic [CH_W-1:0] char_buf[$];
    int              n_directed;
    bit              hold_req  = 1'b0;
    bit              hold_done = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void queue_byte(logic [7:0] d, logic e);
        t_byte_item item;
        item.data = d;
        item.eod  = e;
        byte_q.insert(byte_q.size(), item);
    endfunction

    function automatic void queue_char(logic [CH_W-1:0] c);
        char_buf.insert(char_buf.size(), c);
    endfunction

    // pack the buffered characters lsb first; unused tail bits are random
    function automatic void flush_stream(bit eod);
        logic [7:0]      b;
        logic [CH_W-1:0] c;
        int              nbits;
        int              nbytes;
        int              g;
        nbits  = CH_W * char_buf.size();
        nbytes = (nbits + 7) / 8;
        for (int j = 0; j < nbytes; j++) begin
            for (int k = 0; k < 8; k++) begin
                g = 8 * j + k;
                if (g < nbits) begin
                    c    = char_buf[g / CH_W];
                    b[k] = c[g % CH_W];
                end else begin
                    b[k] = 1'($urandom_range(0, 1));
                end
            end
            queue_byte(b, eod && (j == nbytes - 1));
        end
        char_buf.delete();
    endfunction

    function automatic void add_text(string s);
        byte b8;
        for (int i = 0; i < s.len(); i++) begin
            b8 = s[i];
            queue_char(b8[CH_W-1:0]);
        end
    endfunction

    function automatic void add_token();
        int t;
        t = $urandom_range(0, 9);
        if (t == 0) begin
            queue_char(PREFIX_KEYS[$urandom_range(0, 3)]);
        end else if (t <= 3) begin
            queue_char(CH_BANG);
            queue_char(WORD_KEYS[$urandom_range(0, 8)]);
        end else if (t == 4) begin
            queue_char(CH_BANG);
            queue_char(CH_W'($urandom_range(0, 127)));
        end else if (t == 5) begin
            queue_char(CH_BANG);
            queue_char(PREFIX_KEYS[$urandom_range(0, 3)]);
        end else if (t == 6) begin
            queue_char(CH_BANG);
        end else begin
            queue_char(CH_W'($urandom_range(0, 127)));
        end
    endfunction

    function automatic void add_random_stream();
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            n = $urandom_range(0, 3);
            repeat (n) queue_char(CH_W'($urandom_range(0, 127)));
            add_text("loaded kext");
            n = $urandom_range(1, 12);
            repeat (n) add_token();
            flush_stream($urandom_range(0, 9) != 0);
        end else if (pick == 7) begin
            // near miss on the trigger phrase
            add_text("loaded kext");
            char_buf[$urandom_range(0, TAIL_LEN - 1)] = CH_W'($urandom_range(0, 127));
            n = $urandom_range(1, 8);
            repeat (n) add_token();
            flush_stream(1'b1);
        end else begin
            n = $urandom_range(1, 20);
            repeat (n) begin
                queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
    endfunction

    task automatic drive_bytes();
        t_byte_item item;
        int         burst;
        int         gap;
        int         sent;
        sent = 0;
        @(negedge i_clk);
        while (byte_q.size() != 0) begin
            burst = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
            gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            while (burst > 0 && byte_q.size() != 0) begin
                item              = byte_q.pop_front();
                in_if.valid       = 1'b1;
                in_if.packed_byte = item.data;
                in_if.end_of_data = item.eod;
                @(posedge i_clk);
                while (!in_if.ready) @(posedge i_clk);
                sent++;
                if (sent == n_directed + 40) hold_req = 1'b1;
                @(negedge i_clk);
                burst--;
            end
            if (gap > 0) begin
                in_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        in_if.valid = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) chk.note_byte(in_if.packed_byte, in_if.end_of_data);
            if (out_if.valid && out_if.ready) chk.check_beat(out_if.out_char, out_if.run_last);
        end
    end

    initial begin
        t_rx_mode mode;
        int       seg;
        out_if.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                out_if.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_done = 1'b1;
            end
            mode = t_rx_mode'($urandom_range(0, 3));
            seg  = $urandom_range(8, 64);
            for (int phase = 0; phase < seg; phase++) begin
                case (mode)
                    RX_FREE:   out_if.ready = 1'b1;
                    RX_MOSTLY: out_if.ready = ($urandom_range(0, 9) < 7);
                    RX_SPARSE: out_if.ready = ($urandom_range(0, 9) < 3);
                    default:   out_if.ready = (phase % 3 == 0);
                endcase
                @(negedge i_clk);
            end
        end
    end

    initial begin
        chk               = new();
        in_if.valid       = 1'b0;
        in_if.packed_byte = '0;
        in_if.end_of_data = 1'b0;

        // field extremes and a null character
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7F, 1'b1);
        // trigger, the '@' and '>' prefixes, every word, bang before prefix, plain char, bang and flush
        add_text("loaded kext@!!>!x!A!a!B!C!F!I!P!S!U!");
        flush_stream(1'b1);
        n_directed = byte_q.size();
        while (byte_q.size() < n_directed + RANDOM_BYTES) add_random_stream();

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        drive_bytes();
        while (chk.expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("covered %0d bytes in %0d ended streams, %0d directed", chk.n_bytes,
                 chk.n_streams, n_directed);
        $display("checked %0d character beats, %0d expansions, one long output stall",
                 chk.n_beats, chk.n_expansions);
        if (chk.n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d beats still expected", chk.expected_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
